@@ src/bwa_pkg.sv @@
package bwa_pkg;

  // fixed field widths
  localparam int SAMPLE_WIDTH    = 24;
  localparam int FRAME_LEN_W     = 13;
  localparam int PHASE_W         = 32;
  localparam int ALPHA_W         = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 2;

  // frame and table sizing
  localparam int MAX_FRAME       = 4096;
  localparam int POS_W           = $clog2(MAX_FRAME);
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int IDX_W           = $clog2(COS_TABLE_DEPTH);
  localparam int COS_W           = 18;   // signed Q1.16
  localparam int WIN_W           = 26;   // signed window in Q24
  localparam int PROD_W          = SAMPLE_WIDTH + WIN_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ALPHA = 2'd2;

  // register reset values
  localparam logic [FRAME_LEN_W-1:0] FRAME_LENGTH_RST = 13'd1024;
  localparam logic [PHASE_W-1:0]     PHASE_STEP_RST   = 32'd4198405;
  localparam logic [ALPHA_W-1:0]     WINDOW_ALPHA_RST = 16'd10486;

  // fixed-point constants for the table build
  localparam longint unsigned Q30_ONE  = 64'd1073741824;
  localparam longint unsigned PI_Q30   = 64'd3373259426;
  localparam longint unsigned OCT_SPAN = 64'd536870912;

  typedef logic signed [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic win_load;  // register the window value
    logic out_load;  // register the windowed result
  } bwa_cmd_t;

  // cos on [0, pi/4], Q30 in and out, truncating Horner steps
  function automatic longint unsigned poly_cos(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 12;
    t  = Q30_ONE - ((x2 * t) >> 30) / 2;
    return t;
  endfunction

  // sin on [0, pi/4], Q30 in and out
  function automatic longint unsigned poly_sin(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  // one table entry, octant fold then round to Q1.16
  function automatic logic signed [COS_W-1:0] cos_entry(int unsigned idx);
    longint unsigned p;
    longint unsigned oct;
    longint unsigned r;
    longint unsigned rc;
    longint unsigned xr;
    longint unsigned xc;
    longint unsigned v;
    logic            neg;
    p   = (longint'(idx) << 32) / COS_TABLE_DEPTH;
    oct = (p >> 29) & 64'd7;
    r   = p & (OCT_SPAN - 64'd1);
    rc  = OCT_SPAN - r;
    xr  = (r * PI_Q30) >> 31;
    xc  = (rc * PI_Q30) >> 31;
    case (oct)
      64'd0: begin v = poly_cos(xr); neg = 1'b0; end
      64'd1: begin v = poly_sin(xc); neg = 1'b0; end
      64'd2: begin v = poly_sin(xr); neg = 1'b1; end
      64'd3: begin v = poly_cos(xc); neg = 1'b1; end
      64'd4: begin v = poly_cos(xr); neg = 1'b1; end
      64'd5: begin v = poly_sin(xc); neg = 1'b1; end
      64'd6: begin v = poly_sin(xr); neg = 1'b0; end
      default: begin v = poly_cos(xc); neg = 1'b0; end
    endcase
    v = (v + 64'd8192) >> 14;
    return neg ? -COS_W'(v) : COS_W'(v);
  endfunction

  function automatic cos_rom_t cos_rom_build();
    cos_rom_t rom;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      rom[i] = cos_entry(i);
    end
    return rom;
  endfunction

endpackage

@@ src/blackman_window_apply.sv @@
// Generalized Blackman window on a stream of signed 24-bit samples. Each sample is scaled by
// (1-a)/2 - 0.5cos(2 pi k/(N-1)) + (a/2)cos(4 pi k/(N-1)), with the cosines read from a
// 1024-entry table addressed by a 32-bit phase accumulator that software advances through
// phase_step (ideally round(2^32/(N-1))). Registers: index 0 frame_length (clamped to 2..4096),
// index 1 phase_step, index 2 window_alpha in unsigned Q0.16 (zero gives a Hann window); write
// them only while the block is idle. frame_start_i restarts the frame at this sample, and
// frame_last_o marks the sample at position N-1. An item goes from input transfer through a
// table read, the window sum with the alpha multiplier, then the sample multiplier with
// rounding and saturation. One item is in flight at a time: no new sample is taken until
// the output register is loaded, so the next input can be taken while a result waits
module blackman_window_apply
  import bwa_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           frame_start_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           frame_last_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata_i
);

  // commands from the sequencer to the datapath
  bwa_cmd_t cmd;

  // sequencer: accepts a transfer, steps the datapath, owns output valid
  bwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath: config registers, frame position, cosine table, window and product
  bwa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_in_i   (sample_in_i),
    .frame_start_i (frame_start_i),
    .sample_out_o  (sample_out_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

@@ src/bwa_ctrl.sv @@
module bwa_ctrl
  import bwa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bwa_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o.accept   = accept;
    cmd_o.win_load = 1'b0;
    cmd_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd_o.win_load = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/bwa_datapath.sv @@
module bwa_datapath
  import bwa_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bwa_cmd_t                       cmd_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           frame_start_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           frame_last_o
);

  localparam cos_rom_t CosRom = cos_rom_build();

  localparam logic signed [SAMPLE_WIDTH-1:0] SatMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SatMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // configuration
  logic [FRAME_LEN_W-1:0] frame_length_q;
  logic [PHASE_W-1:0]     phase_step_q;
  logic [ALPHA_W-1:0]     window_alpha_q;

  // frame state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PHASE_W-1:0] phase_q, phase_d;

  // per-item registers
  logic signed [COS_W-1:0]        c1_q, c2_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           last_q;
  logic signed [WIN_W-1:0]        w24_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;
  logic                           out_last_q;

  logic [FRAME_LEN_W-1:0] n_eff;
  logic [FRAME_LEN_W-1:0] n_minus1;
  logic [POS_W-1:0]       pos_eff;
  logic [PHASE_W-1:0]     phase_eff;
  logic [IDX_W-1:0]       idx1, idx2;
  logic                   last;

  // effective frame length clamped to the legal span
  always_comb begin
    if (frame_length_q < FRAME_LEN_W'(2)) begin
      n_eff = FRAME_LEN_W'(2);
    end else if (frame_length_q > FRAME_LEN_W'(MAX_FRAME)) begin
      n_eff = FRAME_LEN_W'(MAX_FRAME);
    end else begin
      n_eff = frame_length_q;
    end
  end

  assign n_minus1  = n_eff - FRAME_LEN_W'(1);
  assign pos_eff   = frame_start_i ? '0 : pos_q;
  assign phase_eff = frame_start_i ? '0 : phase_q;
  assign last      = {{(FRAME_LEN_W-POS_W){1'b0}}, pos_eff} >= n_minus1;
  assign idx1      = phase_eff[PHASE_W-1 -: IDX_W];
  assign idx2      = phase_eff[PHASE_W-2 -: IDX_W];  // twice the phase

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    if (cmd_i.accept) begin
      if (last) begin
        pos_d   = '0;
        phase_d = '0;
      end else begin
        pos_d   = pos_eff + POS_W'(1);
        phase_d = phase_eff + phase_step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FRAME_LENGTH_RST;
      phase_step_q   <= PHASE_STEP_RST;
      window_alpha_q <= WINDOW_ALPHA_RST;
      pos_q          <= '0;
      phase_q        <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_LENGTH: frame_length_q <= cfg_wdata_i[FRAME_LEN_W-1:0];
          REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i[PHASE_W-1:0];
          REG_WINDOW_ALPHA: window_alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // table reads and sample capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c1_q     <= CosRom[idx1];
      c2_q     <= CosRom[idx2];
      sample_q <= sample_in_i;
      last_q   <= last;
    end
  end

  // window value in Q33, rounded to Q24
  logic [ALPHA_W:0]        one_minus_a;
  logic signed [34:0]      a_times_c2;
  logic signed [35:0]      w33;
  logic signed [35:0]      w33_rnd;

  assign one_minus_a = (ALPHA_W+1)'(65536) - {1'b0, window_alpha_q};
  assign a_times_c2  = 35'($signed({1'b0, window_alpha_q})) * 35'(c2_q);
  assign w33         = $signed({3'b000, one_minus_a, 16'h0000})
                     - ($signed(36'(c1_q)) <<< 16)
                     + 36'(a_times_c2);
  assign w33_rnd     = w33 + 36'sd256;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      w24_q <= w33_rnd[34:9];
    end
  end

  // product, round, saturate
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [WIN_W-1:0]  res;
  logic signed [SAMPLE_WIDTH-1:0] res_sat;

  assign prod     = PROD_W'(sample_q) * PROD_W'(w24_q);
  assign prod_rnd = prod + (PROD_W'(1) <<< 23);
  assign res      = prod_rnd[PROD_W-1:24];

  always_comb begin
    if (res > WIN_W'(SatMax)) begin
      res_sat = SatMax;
    end else if (res < WIN_W'(SatMin)) begin
      res_sat = SatMin;
    end else begin
      res_sat = res[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q      <= res_sat;
      out_last_q <= last_q;
    end
  end

  assign sample_out_o = out_q;
  assign frame_last_o = out_last_q;

endmodule

@@ test/window_checker.sv @@
module window_checker
  import bwa_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           frame_start_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_out_i,
  input  logic                           frame_last_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } windowed_t;

  localparam int unsigned     LEN_AT_RESET   = 1024;
  localparam int unsigned     STEP_AT_RESET  = 4198405;
  localparam int unsigned     ALPHA_AT_RESET = 10486;
  localparam longint unsigned UNIT_Q30       = 64'd1073741824;
  localparam longint unsigned ANGLE_PI       = 64'd3373259426;
  localparam longint unsigned EIGHTH_TURN    = 64'd536870912;
  localparam longint          OUT_MAX        = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint          OUT_MIN        = -(longint'(1) <<< (SAMPLE_WIDTH - 1));

  int          cos_lut [COS_TABLE_DEPTH];
  windowed_t   windowed_q [$];
  int unsigned frame_len_reg;
  int unsigned step_reg;
  int unsigned alpha_reg;
  int unsigned pos_cnt;
  logic [31:0] phase_acc;
  int          mismatch_cnt = 0;

  // cosine in Q1.16 from an octant fold and truncating series in Q2.30
  function automatic int cos_q16(int i);
    longint unsigned turn, rem, x, x2, t, mag;
    longint unsigned dv [5];
    int              oct;
    int              k;
    bit              use_sin;
    turn = (longint'(i) << 32) / COS_TABLE_DEPTH;
    oct  = int'(turn >> 29);
    rem  = turn & (EIGHTH_TURN - 1);
    if (oct % 2 == 1) rem = EIGHTH_TURN - rem;
    x       = (rem * ANGLE_PI) >> 31;
    x2      = (x * x) >> 30;
    use_sin = ((oct + 1) & 2) != 0;
    if (use_sin) dv = '{110, 72, 42, 20, 6};
    else dv = '{90, 56, 30, 12, 2};
    t = UNIT_Q30;
    for (k = 0; k < 5; k++) t = UNIT_Q30 - ((x2 * t) >> 30) / dv[k];
    if (use_sin) t = (x * t) >> 30;
    mag = (t + 64'd8192) >> 14;
    return (oct >= 2 && oct <= 5) ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint cos_at(logic [31:0] ph);
    return longint'(cos_lut[int'((64'(ph) * COS_TABLE_DEPTH) >> 32)]);
  endfunction

  // windows one sample and advances the frame position
  function automatic windowed_t apply_window(logic signed [SAMPLE_WIDTH-1:0] s, logic start);
    windowed_t   r;
    int unsigned n_eff;
    longint      a, w33, w24, y;
    n_eff = frame_len_reg;
    if (n_eff < 2) n_eff = 2;
    if (n_eff > MAX_FRAME) n_eff = MAX_FRAME;
    if (start) begin
      pos_cnt   = 0;
      phase_acc = '0;
    end
    a   = longint'(alpha_reg);
    w33 = (65536 - a) * 65536 - cos_at(phase_acc) * 65536 + a * cos_at(phase_acc << 1);
    w24 = (w33 + 256) >>> 9;
    y   = (longint'(s) * w24 + (longint'(1) <<< 23)) >>> 24;
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    r.sample = y[SAMPLE_WIDTH-1:0];
    r.last   = pos_cnt >= n_eff - 1;
    if (r.last) begin
      pos_cnt   = 0;
      phase_acc = '0;
    end else begin
      pos_cnt   = pos_cnt + 1;
      phase_acc = phase_acc + step_reg;
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i < COS_TABLE_DEPTH; i++) cos_lut[i] = cos_q16(i);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    windowed_t want;
    if (!rst_ni) begin
      frame_len_reg = LEN_AT_RESET;
      step_reg      = STEP_AT_RESET;
      alpha_reg     = ALPHA_AT_RESET;
      pos_cnt       = 0;
      phase_acc     = '0;
      windowed_q.delete();
      outstanding_o <= 0;
    end else begin
      // result side first, a result never belongs to an input of the same edge
      if (out_valid_i && out_ready_i) begin
        if (windowed_q.size() == 0) begin
          $display("%0t: unexpected result transfer, sample_out %0d frame_last %0b",
                   $time, sample_out_i, frame_last_i);
          mismatch_cnt++;
        end else begin
          want = windowed_q.pop_front();
          if (sample_out_i !== want.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want.sample, sample_out_i);
            mismatch_cnt++;
          end
          if (frame_last_i !== want.last) begin
            $display("%0t: frame_last mismatch, expected %0b, got %0b",
                     $time, want.last, frame_last_i);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_LENGTH: frame_len_reg = cfg_wdata_i[FRAME_LEN_W-1:0];
          REG_PHASE_STEP:   step_reg      = cfg_wdata_i[PHASE_W-1:0];
          REG_WINDOW_ALPHA: alpha_reg     = cfg_wdata_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        windowed_q = {windowed_q, apply_window(sample_in_i, frame_start_i)};
      end
      outstanding_o <= windowed_q.size();
    end
  end

  assign mismatches_o = mismatch_cnt;

endmodule

@@ test/tb.sv @@
module tb;
  import bwa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int SETTLE      = 8;       // cycles after the last result
  localparam int LONG_HOLD   = 120;     // receiver hold-off that backs the block up
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 92;
  // index 3 decodes to no register, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in   = '0;
  logic                           frame_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           frame_last;
  logic                           cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0]         cfg_index   = REG_FRAME_LENGTH;
  logic [CFG_DATA_W-1:0]          cfg_wdata   = '0;
  logic                           hold_go     = 1'b0;  // asks the receiver for one long hold

  int mismatches;
  int outstanding;
  int cycles     = 0;
  int burst_left = 0;
  int frame_pos  = 0;     // sender's own idea of the frame position
  int n_eff      = 1024;  // frame length the block is using

  blackman_window_apply dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_in_i   (sample_in),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sample_out_o  (sample_out),
    .frame_last_o  (frame_last),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  window_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_in_i   (sample_in),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .sample_out_i  (sample_out),
    .frame_last_i  (frame_last),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #1 clk = ~clk;

  // reset held at the start, then released once
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall patterns of random length, plus hold-offs
  initial begin : receiver
    int mode, left, hold, tick;
    bit held;
    mode = 0;
    left = 0;
    hold = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      // one long hold on request, the sender keeps offering meanwhile
      if (hold_go && !held) begin
        held = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 4);
          left = $urandom_range(16, 160);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;                         // no stalls at all
          1: out_ready <= ($urandom_range(0, 1) == 0);  // coin flip
          2: out_ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
          3: out_ready <= (tick % 5 != 0);              // regular gaps
          default: begin
            // short random hold, then a fresh pattern
            out_ready <= 1'b0;
            hold = $urandom_range(10, 40);
            left = 0;
          end
        endcase
      end
    end
  end

  // clamp the way the block does
  function automatic int effective_len(int unsigned fl);
    if (fl < 2) return 2;
    if (fl > MAX_FRAME) return MAX_FRAME;
    return fl;
  endfunction

  // step that makes the table sweep one frame, round(2^32 / (n - 1))
  function automatic logic [31:0] matched_step(int n);
    longint q;
    q = ((longint'(1) << 32) + (n - 1) / 2) / (n - 1);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
      3:       return SAMPLE_WIDTH'(int'($urandom_range(0, 2)) - 1);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // register writes, only called with the block idle; upper data bits are junk
  task automatic program_regs(input int unsigned fl, input logic [31:0] step,
                              input logic [15:0] alpha, input bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_LENGTH;
    cfg_wdata <= {$urandom} & ~32'h1FFF | (fl & 32'h1FFF);
    @(posedge clk);
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= REG_WINDOW_ALPHA;
    cfg_wdata <= {$urandom} & 32'hFFFF_0000 | alpha;
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_eff  = effective_len(fl & 32'h1FFF);
  endtask

  // one input transfer, with bursts and random gaps in front of it
  task automatic send(input logic signed [SAMPLE_WIDTH-1:0] s, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    sample_in   <= s;
    frame_start <= st;
    do @(posedge clk); while (!in_ready);
    frame_pos = st ? 1 : frame_pos + 1;
    if (frame_pos >= n_eff) frame_pos = 0;
  endtask

  // sender pauses until every result is back, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  // one random setting followed by a stream of samples
  task automatic random_phase(input int count);
    int unsigned fl;
    logic [31:0] step;
    logic [15:0] alpha;
    int          style;
    int          k;
    logic        st;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: fl = $urandom_range(2, 40);
      6:                fl = $urandom_range(0, 1);
      7:                fl = ($urandom_range(0, 1) == 0) ? MAX_FRAME : $urandom_range(4097, 8191);
      8:                fl = $urandom_range(41, 600);
      default:          fl = $urandom_range(2, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       step = $urandom;
      1:       step = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      2:       step = matched_step(effective_len(fl)) + $urandom_range(0, 4096) - 2048;
      default: step = matched_step(effective_len(fl));
    endcase
    case ($urandom_range(0, 4))
      0:       alpha = 16'd0;
      1:       alpha = 16'hFFFF;
      2:       alpha = 16'd10486;
      default: alpha = $urandom;
    endcase
    program_regs(fl, step, alpha, $urandom_range(0, 3) == 0);
    // mostly start flags on frame heads, some streams with none, some with stray ones
    style = $urandom_range(0, 5);
    for (k = 0; k < count; k++) begin
      case (style)
        4:       st = 1'b0;
        5:       st = ($urandom_range(0, 9) == 0);
        default: st = (frame_pos == 0) || ($urandom_range(0, 60) == 0);
      endcase
      send(pick_sample(), st);
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
  endtask

  initial begin : stimulus
    int ph;
    wait (rst_n);
    @(posedge clk);

    // reset settings; start flag on a full-scale sample gives zero window
    send(S_MAX, 1'b1);
    send(S_MIN, 1'b0);
    send('0, 1'b0);
    send(-1, 1'b0);
    send(1, 1'b0);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    drain();

    // frame cut below the current position ends the frame on the next sample
    program_regs(3, 32'h8000_0000, 16'd0, 1'b0);
    send(S_MAX, 1'b0);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MIN, 1'b1);
    drain();

    // length zero clamps to two, full step and alpha, junk write to the spare index
    program_regs(0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MAX, 1'b1);
    send(-1, 1'b0);
    drain();

    // oversize length clamps to the maximum, zero step keeps the window closed
    program_regs(8191, 32'h0, 16'd0, 1'b0);
    send(S_MAX, 1'b1);
    send(S_MIN, 1'b0);
    send(S_MAX, 1'b0);
    drain();

    // length one clamps to two, half-turn step puts the peak on every other sample
    program_regs(1, 32'h8000_0000, 16'd10486, 1'b0);
    send(S_MAX, 1'b1);
    send(S_MAX, 1'b0);
    send(S_MIN, 1'b0);
    send(S_MIN, 1'b0);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 1) hold_go <= 1'b1;
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bwa_pkg.sv
src/bwa_ctrl.sv
src/bwa_datapath.sv
src/blackman_window_apply.sv
test/window_checker.sv
test/tb.sv
